// ===== src/pcf_pkg.sv =====
// palette color filter package: shared colour type, mode codes and constants
// no dependencies; imported by every module of the filter
package pcf_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic valid;
    rgb_t color;
  } beat_t;

  // register indexes
  localparam logic CFG_COLOR_MODE = 1'b0;
  localparam logic CFG_LIGHT_MODE = 1'b1;

  // colour modes
  localparam logic [2:0] COLOR_NONE = 3'd0;
  localparam logic [2:0] COLOR_SEPIA = 3'd1;
  localparam logic [2:0] COLOR_BW = 3'd2;
  localparam logic [2:0] COLOR_GRAY = 3'd3;
  localparam logic [2:0] COLOR_PROJ = 3'd4;

  // light modes
  localparam logic [1:0] LIGHT_NORMAL = 2'd0;
  localparam logic [1:0] LIGHT_NIGHT = 2'd1;
  localparam logic [1:0] LIGHT_DAY = 2'd2;

  // luma and projection weights
  localparam logic [14:0] W_LUMA_R = 15'd30;
  localparam logic [14:0] W_LUMA_G = 15'd59;
  localparam logic [14:0] W_LUMA_B = 15'd11;
  localparam logic [14:0] W_PROJ_RB = 15'd35;
  localparam logic [14:0] W_PROJ_G = 15'd30;

  // floor(x/100) = (x * RECIP_100) >> 24 for every x below 2^17
  localparam logic [17:0] RECIP_100 = 18'd167773;
  localparam int RECIP_100_SHIFT = 24;
  // floor(x/10) = (x * RECIP_10) >> 16 for every x below 2^14
  localparam logic [12:0] RECIP_10 = 13'd6554;
  localparam int RECIP_10_SHIFT = 16;

  localparam logic [7:0] SEPIA_SHIFT = 8'd46;
  localparam logic [7:0] SEPIA_TOP = 8'd209;
  localparam logic [7:0] BW_HIGH_TH = 8'd200;
  localparam logic [7:0] BW_MID_TH = 8'd100;
  localparam logic [7:0] BW_LOW_TH = 8'd50;
  localparam logic [7:0] BW_HIGH = 8'd255;
  localparam logic [7:0] BW_MID = 8'd150;
  localparam logic [7:0] BW_LOW = 8'd76;

  localparam logic [7:0] BRIGHT_LEVEL = 8'd230;
  localparam logic [7:0] W_TINT_RB = 8'd33;
  localparam logic [7:0] W_TINT_G = 8'd34;
  // floor(s/100) < 200 is the same as s < 20000
  localparam logic [15:0] TINT_LIMIT = 16'd20000;

  localparam logic [3:0] K_UNITY = 4'd10;
  localparam logic [3:0] K_DIM = 4'd6;
  localparam logic [3:0] K_BOOST = 4'd15;
  localparam logic [3:0] K_SOFT = 4'd8;
  // c*k/10 above 255 exactly when c*k >= 2560
  localparam logic [11:0] SAT_PRODUCT = 12'd2560;

endpackage

// ===== src/pcf_color_stage.sv =====
// colour stage: weighted sums, divide by 100 and colour mode selection
// two register stages; depends on pcf_pkg
module pcf_color_stage (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [2:0]   color_mode,
  input  pcf_pkg::beat_t in_beat,
  output pcf_pkg::beat_t out_beat
);
  import pcf_pkg::*;

  // stage 1
  logic        s1_valid_r, s1_valid_nxt;
  rgb_t        s1_color_r, s1_color_nxt;
  logic [14:0] s1_luma_sum_r, s1_luma_sum_nxt;
  logic [14:0] s1_proj_sum_r, s1_proj_sum_nxt;
  // stage 2
  logic        s2_valid_r, s2_valid_nxt;
  rgb_t        s2_color_r, s2_color_nxt;

  logic [32:0] luma_prod;
  logic [32:0] proj_prod;
  logic [7:0]  luma;
  logic [7:0]  proj;
  logic [7:0]  bw_level;

  always_comb begin
    s1_valid_nxt = in_beat.valid;
    s1_color_nxt = in_beat.color;
    s1_luma_sum_nxt = 15'(in_beat.color.red) * W_LUMA_R
                    + 15'(in_beat.color.green) * W_LUMA_G
                    + 15'(in_beat.color.blue) * W_LUMA_B;
    s1_proj_sum_nxt = (15'(in_beat.color.red) + 15'(in_beat.color.blue)) * W_PROJ_RB
                    + 15'(in_beat.color.green) * W_PROJ_G;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    s1_color_r <= s1_color_nxt;
    s1_luma_sum_r <= s1_luma_sum_nxt;
    s1_proj_sum_r <= s1_proj_sum_nxt;
  end

  // both sums stay at or below 25500, so each quotient fits in 8 bits
  assign luma_prod = 33'(s1_luma_sum_r) * 33'(RECIP_100);
  assign proj_prod = 33'(s1_proj_sum_r) * 33'(RECIP_100);
  assign luma = luma_prod[RECIP_100_SHIFT +: 8];
  assign proj = proj_prod[RECIP_100_SHIFT +: 8];

  always_comb begin
    if (luma > BW_HIGH_TH) begin
      bw_level = BW_HIGH;
    end else if (luma > BW_MID_TH) begin
      bw_level = BW_MID;
    end else if (luma > BW_LOW_TH) begin
      bw_level = BW_LOW;
    end else begin
      bw_level = 8'd0;
    end
  end

  always_comb begin
    s2_valid_nxt = s1_valid_r;
    s2_color_nxt = s1_color_r;
    case (color_mode)
      COLOR_SEPIA: begin
        s2_color_nxt.red = (luma <= SEPIA_TOP) ? luma + SEPIA_SHIFT : 8'd255;
        s2_color_nxt.green = luma;
        s2_color_nxt.blue = (luma >= SEPIA_SHIFT) ? luma - SEPIA_SHIFT : 8'd0;
      end
      COLOR_BW: begin
        s2_color_nxt = '{bw_level, bw_level, bw_level};
      end
      COLOR_GRAY: begin
        s2_color_nxt = '{luma, luma, luma};
      end
      COLOR_PROJ: begin
        s2_color_nxt.green = proj;
      end
      default: begin
        s2_color_nxt = s1_color_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
    s2_color_r <= s2_color_nxt;
  end

  assign out_beat.valid = s2_valid_r;
  assign out_beat.color = s2_color_r;

endmodule

// ===== src/pcf_light_stage.sv =====
// light stage: tint test and factor pick, product, divide by 10 with saturation
// three register stages; depends on pcf_pkg
module pcf_light_stage (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [1:0]   light_mode,
  input  pcf_pkg::beat_t in_beat,
  output pcf_pkg::beat_t out_beat
);
  import pcf_pkg::*;

  // stage 3
  logic       s3_valid_r, s3_valid_nxt;
  rgb_t       s3_color_r, s3_color_nxt;
  logic [3:0] s3_k_r, s3_k_nxt;
  // stage 4
  logic        s4_valid_r, s4_valid_nxt;
  logic [11:0] s4_prod_r [3];
  logic [11:0] s4_prod_nxt [3];
  // stage 5
  logic       s5_valid_r, s5_valid_nxt;
  rgb_t       s5_color_r, s5_color_nxt;

  logic        bright;
  logic [15:0] tint_sum;
  logic        tinted;
  logic [7:0]  chan [3];
  logic [25:0] quot_prod [3];
  logic [7:0]  scaled [3];

  assign bright = (in_beat.color.red > BRIGHT_LEVEL) || (in_beat.color.green > BRIGHT_LEVEL)
                || (in_beat.color.blue > BRIGHT_LEVEL);
  assign tint_sum = (16'(in_beat.color.red) + 16'(in_beat.color.blue)) * 16'(W_TINT_RB)
                  + 16'(in_beat.color.green) * 16'(W_TINT_G);
  assign tinted = bright && (tint_sum < TINT_LIMIT);

  always_comb begin
    s3_valid_nxt = in_beat.valid;
    s3_color_nxt = in_beat.color;
    case (light_mode)
      LIGHT_NIGHT: s3_k_nxt = tinted ? K_BOOST : K_DIM;
      LIGHT_DAY:   s3_k_nxt = tinted ? K_SOFT : K_BOOST;
      // times ten over ten leaves the channel as it is
      default:     s3_k_nxt = K_UNITY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s3_valid_nxt;
    end
    s3_color_r <= s3_color_nxt;
    s3_k_r <= s3_k_nxt;
  end

  assign chan[0] = s3_color_r.red;
  assign chan[1] = s3_color_r.green;
  assign chan[2] = s3_color_r.blue;

  always_comb begin
    s4_valid_nxt = s3_valid_r;
    for (int i = 0; i < 3; i++) begin
      s4_prod_nxt[i] = 12'(chan[i]) * 12'(s3_k_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s4_valid_nxt;
    end
    s4_prod_r <= s4_prod_nxt;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quot_prod[i] = 26'(s4_prod_r[i]) * 26'(RECIP_10);
      scaled[i] = (s4_prod_r[i] >= SAT_PRODUCT) ? 8'd255 : quot_prod[i][RECIP_10_SHIFT +: 8];
    end
    s5_valid_nxt = s4_valid_r;
    s5_color_nxt = '{scaled[0], scaled[1], scaled[2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else begin
      s5_valid_r <= s5_valid_nxt;
    end
    s5_color_r <= s5_color_nxt;
  end

  assign out_beat.valid = s5_valid_r;
  assign out_beat.color = s5_color_r;

endmodule

// ===== src/palette_color_filter_core.sv =====
// palette color filter top level: mode registers and the five-stage pipeline
// depends on pcf_pkg, pcf_color_stage and pcf_light_stage
//
//   channel  ports                                   handshake
//   input    in_red_in, in_green_in, in_blue_in      start && !busy
//   result   out_red_out, out_green_out, out_blue_out out_valid, one cycle
//   config   cfg_index, cfg_data                     cfg_we
//
// one beat per clock; each result passes through the five register stages
// (sums, divide by 100, tint test, product, divide by 10) after its start
// beat. busy is always low and the receiver cannot stall, so no stage
// ever holds. synchronous reset clears the valid bits and sets both mode
// registers to zero.
module palette_color_filter_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  output logic       out_valid,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data
);
  import pcf_pkg::*;

  logic [2:0] color_mode_r, color_mode_nxt;
  logic [1:0] light_mode_r, light_mode_nxt;
  beat_t      in_beat;
  beat_t      mid_beat;
  beat_t      res_beat;

  always_comb begin
    color_mode_nxt = color_mode_r;
    light_mode_nxt = light_mode_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_COLOR_MODE: color_mode_nxt = cfg_data;
        CFG_LIGHT_MODE: light_mode_nxt = cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= COLOR_NONE;
      light_mode_r <= LIGHT_NORMAL;
    end else begin
      color_mode_r <= color_mode_nxt;
      light_mode_r <= light_mode_nxt;
    end
  end

  assign busy = 1'b0;
  assign in_beat.valid = start && !busy;
  assign in_beat.color = '{in_red_in, in_green_in, in_blue_in};

  pcf_color_stage u_color (
    .clk        (clk),
    .rst_n      (rst_n),
    .color_mode (color_mode_r),
    .in_beat    (in_beat),
    .out_beat   (mid_beat)
  );

  pcf_light_stage u_light (
    .clk        (clk),
    .rst_n      (rst_n),
    .light_mode (light_mode_r),
    .in_beat    (mid_beat),
    .out_beat   (res_beat)
  );

  assign out_valid = res_beat.valid;
  assign out_red_out = res_beat.color.red;
  assign out_green_out = res_beat.color.green;
  assign out_blue_out = res_beat.color.blue;

endmodule
